[src/pwb_pkg.sv]
// ----------------------------------------------------------------------------
// pwb_pkg
// Shared types, constants and helpers for the particle wall bounce pipeline.
// ----------------------------------------------------------------------------
package pwb_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FracBitsDefault = 16;

  // Reset values of the box size registers.
  localparam logic [30:0] ArenaWidthReset  = 31'd52428800;
  localparam logic [30:0] ArenaHeightReset = 31'd39321600;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ARENA_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ARENA_HEIGHT = 2'd1;

  // Wall that was hit.
  typedef enum logic [2:0] {
    HIT_NONE   = 3'd0,
    HIT_BOTTOM = 3'd1,
    HIT_TOP    = 3'd2,
    HIT_LEFT   = 3'd3,
    HIT_RIGHT  = 3'd4
  } hit_t;

  // Per-particle data carried alongside the divider.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] nvx;
    logic signed [31:0] nvy;
    logic        [30:0] t;
    logic signed [31:0] top;
    logic signed [31:0] right;
    hit_t               hit;
    logic signed [31:0] tx_sat;
    logic signed [31:0] ty_sat;
  } pwb_side_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] res;
    if (x > 72'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (x < -72'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Magnitude with the most negative value saturated.
  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
    logic signed [31:0] res;
    if (v == 32'sh80000000) begin
      res = 32'sh7fffffff;
    end else if (v < 0) begin
      res = -v;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[src/pwb_front.sv]
// ----------------------------------------------------------------------------
// pwb_front
// Projects the particle over the full time step and picks the wall hit in priority order.
// ----------------------------------------------------------------------------
module pwb_front #(
  parameter int FRAC_BITS = pwb_pkg::FracBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    vel_x,
  input  logic signed [31:0]    vel_y,
  input  logic        [30:0]    radius,
  input  logic        [30:0]    time_left,
  input  logic        [30:0]    arena_width,
  input  logic        [30:0]    arena_height,
  output logic                  out_valid,
  output pwb_pkg::pwb_side_t    out_side,
  output logic signed [33:0]    out_num,
  output logic signed [31:0]    out_den
);
  import pwb_pkg::*;

  // Stage A registers.
  logic               va_r;
  logic signed [31:0] px_a_r, py_a_r, vx_a_r, vy_a_r;
  logic        [30:0] r_a_r, t_a_r;
  logic signed [31:0] top_a_r, right_a_r;
  logic signed [63:0] pvx_a_r, pvy_a_r;

  // Stage B registers.
  logic               vb_r;
  pwb_side_t          side_b_r;
  logic signed [33:0] num_b_r;
  logic signed [31:0] den_b_r;

  // Stage B logic.
  logic signed [63:0] tx, ty, r64, top64, right64;
  pwb_side_t          side_nxt;
  logic signed [33:0] num_nxt;
  logic signed [31:0] den_nxt;

  // Stage A: products of velocity and time, wall limits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    px_a_r    <= pos_x;
    py_a_r    <= pos_y;
    vx_a_r    <= vel_x;
    vy_a_r    <= vel_y;
    r_a_r     <= radius;
    t_a_r     <= time_left;
    top_a_r   <= $signed({1'b0, arena_height}) - $signed({1'b0, radius});
    right_a_r <= $signed({1'b0, arena_width}) - $signed({1'b0, radius});
    pvx_a_r   <= 64'(vel_x) * $signed({33'd0, time_left});
    pvy_a_r   <= 64'(vel_y) * $signed({33'd0, time_left});
  end

  // Stage B: projected position and wall choice in priority order.
  always_comb begin
    tx      = 64'(px_a_r) + (pvx_a_r >>> FRAC_BITS);
    ty      = 64'(py_a_r) + (pvy_a_r >>> FRAC_BITS);
    r64     = $signed({33'd0, r_a_r});
    top64   = 64'(top_a_r);
    right64 = 64'(right_a_r);
    num_nxt = '0;
    den_nxt = '0;
    side_nxt.px     = px_a_r;
    side_nxt.py     = py_a_r;
    side_nxt.vx     = vx_a_r;
    side_nxt.vy     = vy_a_r;
    side_nxt.nvx    = vx_a_r;
    side_nxt.nvy    = vy_a_r;
    side_nxt.t      = t_a_r;
    side_nxt.top    = top_a_r;
    side_nxt.right  = right_a_r;
    side_nxt.hit    = HIT_NONE;
    side_nxt.tx_sat = sat32(72'(tx));
    side_nxt.ty_sat = sat32(72'(ty));
    if (t_a_r != '0) begin
      if (ty < r64) begin
        side_nxt.hit = HIT_BOTTOM;
        num_nxt      = $signed({3'd0, r_a_r}) - 34'(py_a_r);
        den_nxt      = vy_a_r;
        side_nxt.nvy = abs_sat(vy_a_r);
      end else if (ty > top64) begin
        side_nxt.hit = HIT_TOP;
        num_nxt      = 34'(top_a_r) - 34'(py_a_r);
        den_nxt      = vy_a_r;
        side_nxt.nvy = -abs_sat(vy_a_r);
      end else if (tx < r64) begin
        side_nxt.hit = HIT_LEFT;
        num_nxt      = $signed({3'd0, r_a_r}) - 34'(px_a_r);
        den_nxt      = vx_a_r;
        side_nxt.nvx = abs_sat(vx_a_r);
      end else if (tx > right64) begin
        side_nxt.hit = HIT_RIGHT;
        num_nxt      = 34'(right_a_r) - 34'(px_a_r);
        den_nxt      = vx_a_r;
        side_nxt.nvx = -abs_sat(vx_a_r);
      end
    end
    // A still component never reaches its wall: no bounce.
    if (den_nxt == '0) begin
      side_nxt.hit = HIT_NONE;
      side_nxt.nvx = vx_a_r;
      side_nxt.nvy = vy_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    side_b_r <= side_nxt;
    num_b_r  <= num_nxt;
    den_b_r  <= den_nxt;
  end

  assign out_valid = vb_r;
  assign out_side  = side_b_r;
  assign out_num   = num_b_r;
  assign out_den   = den_b_r;

endmodule

[src/pwb_div.sv]
// ----------------------------------------------------------------------------
// pwb_div
// Pipelined restoring divider, one quotient bit per stage, giving
// (num << FRAC_BITS) / den truncated toward zero, with sideband data.
// ----------------------------------------------------------------------------
module pwb_div #(
  parameter int FRAC_BITS = pwb_pkg::FracBitsDefault,
  parameter int QW        = 33 + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pwb_pkg::pwb_side_t    in_side,
  input  logic signed [33:0]    in_num,
  input  logic signed [31:0]    in_den,
  output logic                  out_valid,
  output pwb_pkg::pwb_side_t    out_side,
  output logic                  out_neg,
  output logic        [QW-1:0]  out_quot
);
  import pwb_pkg::*;

  // Stage k holds the state after k quotient bits.
  logic              v_r    [0:QW];
  pwb_side_t         side_r [0:QW];
  logic              neg_r  [0:QW];
  logic [QW-1:0]     n_r    [0:QW];
  logic [QW-1:0]     q_r    [0:QW];
  logic [31:0]       rem_r  [0:QW];
  logic [31:0]       d_r    [0:QW];

  logic [33:0]       num_mag;
  logic [31:0]       den_mag;

  // Stage zero is the magnitude form of the incoming beat.
  always_comb begin
    num_mag   = in_num[33] ? 34'(-in_num) : 34'(in_num);
    den_mag   = in_den[31] ? 32'(-in_den) : 32'(in_den);
    v_r[0]    = in_valid;
    side_r[0] = in_side;
    neg_r[0]  = in_num[33] ^ in_den[31];
    n_r[0]    = {num_mag[32:0], {FRAC_BITS{1'b0}}};
    q_r[0]    = '0;
    rem_r[0]  = '0;
    d_r[0]    = den_mag;
  end

  // One shift and trial subtract per stage.
  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [32:0] shifted;
    logic        ge;
    assign shifted = {rem_r[g], n_r[g][QW-1]};
    assign ge      = shifted >= {1'b0, d_r[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
      side_r[g+1] <= side_r[g];
      neg_r[g+1]  <= neg_r[g];
      d_r[g+1]    <= d_r[g];
      n_r[g+1]    <= n_r[g] << 1;
      q_r[g+1]    <= {q_r[g][QW-2:0], ge};
      rem_r[g+1]  <= ge ? 32'(shifted - {1'b0, d_r[g]}) : shifted[31:0];
    end
  end

  assign out_valid = v_r[QW];
  assign out_side  = side_r[QW];
  assign out_neg   = neg_r[QW];
  assign out_quot  = q_r[QW];

endmodule

[src/pwb_back.sv]
// ----------------------------------------------------------------------------
// pwb_back
// Moves the particle to the wall, reflects, moves for the rest of the time
// (or straight on without a hit), then clamps top and right overshoot.
// ----------------------------------------------------------------------------
module pwb_back #(
  parameter int FRAC_BITS = pwb_pkg::FracBitsDefault,
  parameter int QW        = 33 + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pwb_pkg::pwb_side_t    in_side,
  input  logic                  in_neg,
  input  logic        [QW-1:0]  in_quot,
  output logic                  out_valid,
  output logic signed [31:0]    new_pos_x,
  output logic signed [31:0]    new_pos_y,
  output logic signed [31:0]    new_vel_x,
  output logic signed [31:0]    new_vel_y,
  output logic        [2:0]     wall_hit
);
  import pwb_pkg::*;

  // Stage E: collision time and remaining time.
  logic               ve_r;
  pwb_side_t          se_r;
  logic signed [31:0] ct_e_r;
  logic signed [33:0] rem_e_r;
  logic signed [71:0] q_signed;
  logic signed [31:0] ct_nxt;

  always_comb begin
    q_signed = in_neg ? -$signed(72'(in_quot)) : $signed(72'(in_quot));
    ct_nxt   = sat32(q_signed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= in_valid;
    end
    se_r    <= in_side;
    ct_e_r  <= ct_nxt;
    rem_e_r <= $signed({3'd0, in_side.t}) - 34'(ct_nxt);
  end

  // Stage F: travel up to the wall.
  logic               vf_r;
  pwb_side_t          sf_r;
  logic signed [33:0] rem_f_r;
  logic signed [63:0] mx_f_r, my_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= ve_r;
    end
    sf_r    <= se_r;
    rem_f_r <= rem_e_r;
    mx_f_r  <= 64'(se_r.vx) * 64'(ct_e_r);
    my_f_r  <= 64'(se_r.vy) * 64'(ct_e_r);
  end

  // Stage G: position at the wall.
  logic               vg_r;
  pwb_side_t          sg_r;
  logic signed [33:0] rem_g_r;
  logic signed [31:0] px_g_r, py_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else begin
      vg_r <= vf_r;
    end
    sg_r    <= sf_r;
    rem_g_r <= rem_f_r;
    px_g_r  <= sat32(72'(sf_r.px) + 72'(mx_f_r >>> FRAC_BITS));
    py_g_r  <= sat32(72'(sf_r.py) + 72'(my_f_r >>> FRAC_BITS));
  end

  // Stage H: travel with the reflected velocity.
  logic               vh_r;
  pwb_side_t          sh_r;
  logic signed [31:0] px_h_r, py_h_r;
  logic signed [65:0] mx_h_r, my_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else begin
      vh_r <= vg_r;
    end
    sh_r   <= sg_r;
    px_h_r <= px_g_r;
    py_h_r <= py_g_r;
    mx_h_r <= 66'(sg_r.nvx) * 66'(rem_g_r);
    my_h_r <= 66'(sg_r.nvy) * 66'(rem_g_r);
  end

  // Stage I: final position, path select and clamp.
  logic               vi_r;
  logic signed [31:0] px_i_r, py_i_r, vx_i_r, vy_i_r;
  logic        [2:0]  hit_i_r;
  logic signed [31:0] px_sel, py_sel;

  always_comb begin
    if (sh_r.t == '0) begin
      px_sel = sh_r.px;
      py_sel = sh_r.py;
    end else if (sh_r.hit == HIT_NONE) begin
      px_sel = sh_r.tx_sat;
      py_sel = sh_r.ty_sat;
    end else begin
      px_sel = sat32(72'(px_h_r) + 72'(mx_h_r >>> FRAC_BITS));
      py_sel = sat32(72'(py_h_r) + 72'(my_h_r >>> FRAC_BITS));
    end
    if (py_sel > sh_r.top) begin
      py_sel = sh_r.top;
    end
    if (px_sel > sh_r.right) begin
      px_sel = sh_r.right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
    end else begin
      vi_r <= vh_r;
    end
    px_i_r  <= px_sel;
    py_i_r  <= py_sel;
    vx_i_r  <= sh_r.nvx;
    vy_i_r  <= sh_r.nvy;
    hit_i_r <= sh_r.hit;
  end

  assign out_valid = vi_r;
  assign new_pos_x = px_i_r;
  assign new_pos_y = py_i_r;
  assign new_vel_x = vx_i_r;
  assign new_vel_y = vy_i_r;
  assign wall_hit  = hit_i_r;

endmodule

[src/particle_wall_bounce_step.sv]
// ----------------------------------------------------------------------------
// particle_wall_bounce_step
// One-particle wall bounce inside a configurable box, fully pipelined.
//
//   channel  | handshake               | beat
//   ---------+-------------------------+---------------------------------
//   input    | start & !busy           | in_pos/vel x,y, radius, time_left
//   result   | out_valid (one cycle)   | out_new_pos/vel x,y, wall_hit
//   config   | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// One beat is accepted every cycle; busy is always low.
// The pipeline has two front stages, 33 + FRAC_BITS
// divider stages (one quotient bit each) and five back stages.
// Reset clears all valid bits; the box size returns to 800.0 by 600.0.
// The receiver cannot stall, so results leave in order, one per beat.
// ----------------------------------------------------------------------------
module particle_wall_bounce_step #(
  parameter int FRAC_BITS = pwb_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic        [30:0] in_radius,
  input  logic        [30:0] in_time_left,
  output logic               out_valid,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic        [2:0]  out_wall_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  import pwb_pkg::*;

  localparam int QW = 33 + FRAC_BITS;

  logic [30:0]        arena_width_r, arena_height_r;
  logic               fv, dv;
  pwb_side_t          f_side, d_side;
  logic signed [33:0] f_num;
  logic signed [31:0] f_den;
  logic               d_neg;
  logic [QW-1:0]      d_quot;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Box size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_width_r  <= ArenaWidthReset;
      arena_height_r <= ArenaHeightReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ARENA_WIDTH:  arena_width_r  <= cfg_data[30:0];
        CFG_ARENA_HEIGHT: arena_height_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  pwb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start && !busy),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .vel_x        (in_vel_x),
    .vel_y        (in_vel_y),
    .radius       (in_radius),
    .time_left    (in_time_left),
    .arena_width  (arena_width_r),
    .arena_height (arena_height_r),
    .out_valid    (fv),
    .out_side     (f_side),
    .out_num      (f_num),
    .out_den      (f_den)
  );

  pwb_div #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv),
    .in_side   (f_side),
    .in_num    (f_num),
    .in_den    (f_den),
    .out_valid (dv),
    .out_side  (d_side),
    .out_neg   (d_neg),
    .out_quot  (d_quot)
  );

  pwb_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv),
    .in_side   (d_side),
    .in_neg    (d_neg),
    .in_quot   (d_quot),
    .out_valid (out_valid),
    .new_pos_x (out_new_pos_x),
    .new_pos_y (out_new_pos_y),
    .new_vel_x (out_new_vel_x),
    .new_vel_y (out_new_vel_y),
    .wall_hit  (out_wall_hit)
  );

endmodule

[tb/particle_wall_bounce_step_test.sv]
// ----------------------------------------------------------------------------
// particle_wall_bounce_step_test
// Self-checking bench for the particle wall bounce pipeline.
//
// Particles are driven on the command port with random gaps. Each accepted
// beat is run through a bounce predictor in the scoreboard. Results are then
// compared field by field, in order, as they leave the block. The box size
// is rewritten between phases once the pipeline has drained. The settings
// include zero, full scale and random sizes.
// ----------------------------------------------------------------------------
module particle_wall_bounce_step_test;
  import pwb_pkg::*;

  localparam int FracBits = FracBitsDefault;
  localparam int Latency  = FracBits + 40;

  // One particle as it enters the block.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [30:0] radius;
    logic        [30:0] tleft;
  } particle_t;

  // One particle as it leaves the block.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [2:0]  hit;
  } bounce_t;

  // Bounce predictor and queue of predicted particles.
  class bounce_scoreboard;
    longint   box_w;
    longint   box_h;
    bounce_t  predicted[$];
    int       mismatches;

    function new();
      box_w = ArenaWidthReset;
      box_h = ArenaHeightReset;
      mismatches = 0;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Fixed-point product, rounded toward minus infinity.
    function longint fx_mul(longint a, longint b);
      return (a * b) >>> FracBits;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? clip32(-v) : v;
    endfunction

    function void note_particle(particle_t p);
      longint px, py, vx, vy, r, t, top, right, ty, tx, num, den, nvx, nvy, ct, rem;
      hit_t hit;
      bounce_t res;
      px = p.px; py = p.py; vx = p.vx; vy = p.vy;
      r = p.radius; t = p.tleft;
      top = box_h - r;
      right = box_w - r;
      hit = HIT_NONE;
      if (t != 0) begin
        ty = py + fx_mul(vy, t);
        tx = px + fx_mul(vx, t);
        num = 0; den = 0; nvx = vx; nvy = vy;
        // Only the first wall in priority order counts.
        if (ty < r) begin
          hit = HIT_BOTTOM; num = r - py; den = vy; nvy = mag(vy);
        end else if (ty > top) begin
          hit = HIT_TOP; num = top - py; den = vy; nvy = -mag(vy);
        end else if (tx < r) begin
          hit = HIT_LEFT; num = r - px; den = vx; nvx = mag(vx);
        end else if (tx > right) begin
          hit = HIT_RIGHT; num = right - px; den = vx; nvx = -mag(vx);
        end
        if (hit != HIT_NONE && den == 0) hit = HIT_NONE;
        if (hit != HIT_NONE) begin
          ct = clip32((num * (64'sd1 << FracBits)) / den);
          rem = t - ct;
          px = clip32(px + fx_mul(vx, ct));
          py = clip32(py + fx_mul(vy, ct));
          vx = nvx;
          vy = nvy;
          px = clip32(px + fx_mul(vx, rem));
          py = clip32(py + fx_mul(vy, rem));
        end else begin
          px = clip32(tx);
          py = clip32(ty);
        end
      end
      // Overshoot past the top and right walls is clamped.
      if (py > top) py = top;
      if (px > right) px = right;
      res.px = px[31:0]; res.py = py[31:0];
      res.vx = vx[31:0]; res.vy = vy[31:0];
      res.hit = hit;
      predicted.push_back(res);
    endfunction

    function void check_bounce(bounce_t got);
      bounce_t want;
      if (predicted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: x=%0d y=%0d", got.px, got.py);
        return;
      end
      want = predicted.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.vx !== want.vx ||
          got.vy !== want.vy || got.hit !== want.hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected x=%0d y=%0d vx=%0d vy=%0d hit=%0d,",
                   want.px, want.py, want.vx, want.vy, want.hit,
                   " got x=%0d y=%0d vx=%0d vy=%0d hit=%0d",
                   got.px, got.py, got.vx, got.vy, got.hit);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic        [30:0] in_radius = '0;
  logic        [30:0] in_time_left = '0;
  logic               out_valid;
  logic signed [31:0] out_new_pos_x;
  logic signed [31:0] out_new_pos_y;
  logic signed [31:0] out_new_vel_x;
  logic signed [31:0] out_new_vel_y;
  logic        [2:0]  out_wall_hit;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  bounce_scoreboard sb = new();

  particle_wall_bounce_step #(.FRAC_BITS(FracBits)) u_dut (.*);

  always #1 clk = ~clk;

  // Note accepted particles and check result beats.
  always @(posedge clk) begin
    particle_t p;
    bounce_t b;
    if (rst_n && start && !busy) begin
      p.px = in_pos_x; p.py = in_pos_y; p.vx = in_vel_x; p.vy = in_vel_y;
      p.radius = in_radius; p.tleft = in_time_left;
      sb.note_particle(p);
    end
    if (rst_n && out_valid) begin
      b.px = out_new_pos_x; b.py = out_new_pos_y;
      b.vx = out_new_vel_x; b.vy = out_new_vel_y; b.hit = out_wall_hit;
      sb.check_bounce(b);
    end
  end

  // Drive one particle after a random gap and hold it until accepted.
  task automatic send_particle(particle_t p);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pos_x <= p.px; in_pos_y <= p.py; in_vel_x <= p.vx; in_vel_y <= p.vy;
    in_radius <= p.radius; in_time_left <= p.tleft;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write one box register; only called while the pipeline is empty.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ARENA_WIDTH) sb.box_w = data[30:0];
    else sb.box_h = data[30:0];
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.predicted.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic particle_t mk(longint px, longint py, longint vx, longint vy,
                                   longint r, longint t);
    particle_t p;
    p.px = px[31:0]; p.py = py[31:0]; p.vx = vx[31:0]; p.vy = vy[31:0];
    p.radius = r[30:0]; p.tleft = t[30:0];
    return p;
  endfunction

  // Mostly particles inside the box with modest motion, some raw noise.
  function automatic particle_t random_particle();
    particle_t p;
    longint w, h;
    w = sb.box_w; h = sb.box_h;
    if ($urandom_range(0, 7) == 0) begin
      p.px = $urandom; p.py = $urandom; p.vx = $urandom; p.vy = $urandom;
      p.radius = 31'($urandom); p.tleft = 31'($urandom);
    end else begin
      p.px = (w == 0) ? 32'($urandom_range(0, 65535)) : 32'(longint'($urandom) % (w + 1));
      p.py = (h == 0) ? 32'($urandom_range(0, 65535)) : 32'(longint'($urandom) % (h + 1));
      p.vx = $signed($urandom) >>> $urandom_range(4, 14);
      p.vy = $signed($urandom) >>> $urandom_range(4, 14);
      p.radius = 31'($urandom) >> $urandom_range(8, 30);
      p.tleft = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom) >> $urandom_range(12, 28);
      if ($urandom_range(0, 15) == 0) p.vx = 32'sh80000000;
      if ($urandom_range(0, 15) == 0) p.vy = '0;
    end
    return p;
  endfunction

  initial begin
    longint one;
    one = 64'sd1 << FracBits;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed particles under the reset box of 800 by 600.
    send_particle(mk(100 * one, 100 * one, 5 * one, 5 * one, one, 0));
    send_particle(mk(900 * one, 700 * one, 0, 0, one, 0));
    send_particle(mk(100 * one, 100 * one, 10 * one, 20 * one, 2 * one, one));
    send_particle(mk(100 * one, 5 * one, 3 * one, -20 * one, 2 * one, one));
    send_particle(mk(100 * one, 590 * one, 3 * one, 30 * one, 2 * one, one));
    send_particle(mk(5 * one, 300 * one, -20 * one, 1 * one, 2 * one, one));
    send_particle(mk(790 * one, 300 * one, 30 * one, -1 * one, 2 * one, one));
    send_particle(mk(100 * one, 300 * one, -200 * one, -200 * one, one, 2 * one));
    send_particle(mk(100 * one, 0, 0, 0, 10 * one, one));
    send_particle(mk(0, 300 * one, 0, 0, 10 * one, one));
    send_particle(mk(100 * one, 300 * one, 32'sh80000000, 0, one, one));
    send_particle(mk(100 * one, 300 * one, 0, 32'sh80000000, one, one));
    send_particle(mk(100 * one, 300 * one, 32'sh7fffffff, 32'sh7fffffff, one, 31'h7fffffff));
    send_particle(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 31'h7fffffff));
    send_particle(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 1));
    send_particle(mk(10 * one, 10 * one, one, one, 700 * one, one));
    send_particle(mk(400 * one, 300 * one, 50 * one, -50 * one, 31'h7fffffff, 3 * one));
    send_particle(mk(50 * one, 2 * one, -100, -3 * one, 4 * one, 31'h7fffffff));
    send_particle(mk(400 * one, 300 * one, 1, -1, 0, 1));
    send_particle(mk(-5 * one, -5 * one, 0, 0, 0, one));
    drain();

    // Random phases under several box sizes, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_ARENA_WIDTH, 32'h0);
          write_reg(CFG_ARENA_HEIGHT, 32'h8000_0000);
        end
        2: begin
          write_reg(CFG_ARENA_WIDTH, 32'hffff_ffff);
          write_reg(CFG_ARENA_HEIGHT, 32'h7fff_ffff);
        end
        3: begin
          write_reg(CFG_ARENA_WIDTH, 32'(100 * one));
          write_reg(CFG_ARENA_HEIGHT, 32'(50 * one));
        end
        default: begin
          write_reg(CFG_ARENA_WIDTH, $urandom);
          write_reg(CFG_ARENA_HEIGHT, $urandom >> $urandom_range(0, 12));
        end
      endcase
      repeat (222) send_particle(random_particle());
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
